FILE: rtl/vab_pkg.sv
// Package for the vector angle block: payload structs, internal stage structs,
// fixed-point widths and the CORDIC arctangent table function.
// No dependencies.
`default_nettype none

package vab_pkg;

    localparam int COORD_BITS       = 16;
    localparam int ANGLE_BITS       = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int SUM_W       = PROD_W + 1;
    localparam int NEG_W       = SUM_W + 1;
    localparam int FRAC_BITS   = 62;
    localparam int Z_W         = FRAC_BITS;
    localparam int XY_W        = 63;
    localparam int M_W         = 60;
    localparam int NORM_STAGES = 6;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [Z_W-1:0] HALF_TURN   = Z_W'(1) << (Z_W - 1);
    localparam logic [Z_W-1:0] ROUND_HALF  = Z_W'(1) << (Z_W - ANGLE_BITS - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } vab_in_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] turn_angle;
        logic                  degenerate;
    } vab_out_t;

    typedef struct packed {
        logic                   valid;
        logic                   degenerate;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
        logic [M_W-1:0]         mag;
    } vab_norm_t;

    typedef struct packed {
        logic                   valid;
        logic                   degenerate;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
    } vab_rot_t;

    // Arctangent of 2^-step in Q62 turns, evaluated at elaboration only.
    function automatic logic [Z_W-1:0] atan_turn(input int step);
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] prod;
        int           k;
        int           e;
        rad = 64'd0;
        if (step == 0) begin
            return Z_W'(1) << (FRAC_BITS - 3);
        end
        for (k = 0; k < FRAC_BITS; k++) begin
            if (step * (2 * k + 1) <= FRAC_BITS) begin
                e    = FRAC_BITS - step * (2 * k + 1);
                term = (64'd1 << e) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    rad = rad - term;
                end else begin
                    rad = rad + term;
                end
            end
        end
        prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
        return prod[64 +: Z_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vab_norm_cell.sv
// One normalization cell: shifts the vector pair left by a fixed amount when
// the magnitude leaves room for it. Depends on vab_pkg.
`default_nettype none

module vab_norm_cell #(
    parameter int SHIFT = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire vab_pkg::vab_norm_t cell_in,
    output vab_pkg::vab_norm_t     cell_out
);

    vab_pkg::vab_norm_t stage_reg;
    vab_pkg::vab_norm_t stage_next;
    logic               do_shift;

    always_comb begin
        do_shift   = (cell_in.mag[vab_pkg::M_W-1 -: SHIFT] == '0);
        stage_next = cell_in;
        if (do_shift) begin
            stage_next.x   = cell_in.x <<< SHIFT;
            stage_next.y   = cell_in.y <<< SHIFT;
            stage_next.mag = cell_in.mag << SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg.valid <= stage_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg.degenerate <= stage_next.degenerate;
            stage_reg.x          <= stage_next.x;
            stage_reg.y          <= stage_next.y;
            stage_reg.z          <= stage_next.z;
            stage_reg.mag        <= stage_next.mag;
        end
    end

    assign cell_out = stage_reg;

endmodule

`default_nettype wire

FILE: rtl/vab_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with its own arctangent
// constant, registered. Depends on vab_pkg.
`default_nettype none

module vab_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire vab_pkg::vab_rot_t cell_in,
    output vab_pkg::vab_rot_t     cell_out
);

    localparam logic [vab_pkg::Z_W-1:0] ATAN = vab_pkg::atan_turn(STEP);

    vab_pkg::vab_rot_t               stage_reg;
    vab_pkg::vab_rot_t               stage_next;
    logic signed [vab_pkg::XY_W-1:0] xs;
    logic signed [vab_pkg::XY_W-1:0] ys;

    always_comb begin
        xs         = cell_in.x >>> STEP;
        ys         = cell_in.y >>> STEP;
        stage_next = cell_in;
        if (cell_in.y[vab_pkg::XY_W-1]) begin
            stage_next.x = cell_in.x - ys;
            stage_next.y = cell_in.y + xs;
            stage_next.z = cell_in.z - ATAN;
        end else begin
            stage_next.x = cell_in.x + ys;
            stage_next.y = cell_in.y - xs;
            stage_next.z = cell_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg.valid <= stage_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg.degenerate <= stage_next.degenerate;
            stage_reg.x          <= stage_next.x;
            stage_reg.y          <= stage_next.y;
            stage_reg.z          <= stage_next.z;
        end
    end

    assign cell_out = stage_reg;

endmodule

`default_nettype wire

FILE: rtl/vab_skid.sv
// Two-entry output skid buffer for result transactions; its ready is a register.
// Depends on vab_pkg.
`default_nettype none

module vab_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire vab_pkg::vab_out_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output vab_pkg::vab_out_t     out_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              spare_valid_reg;
    logic              spare_valid_next;
    vab_pkg::vab_out_t main_reg;
    vab_pkg::vab_out_t main_next;
    vab_pkg::vab_out_t spare_reg;
    vab_pkg::vab_out_t spare_next;
    logic              in_fire;
    logic              out_fire;

    always_comb begin
        in_fire          = in_valid && !spare_valid_reg;
        out_fire         = main_valid_reg && out_ready;
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_next        = main_reg;
        spare_next       = spare_reg;
        if (spare_valid_reg) begin
            if (out_fire) begin
                main_next        = spare_reg;
                spare_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!main_valid_reg || out_fire) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                spare_next       = in_data;
                spare_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign in_ready  = !spare_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire

FILE: rtl/vector_angle_between.sv
// Counterclockwise angle from vector a to vector b by a pipelined CORDIC chain.
// Throughput: one transaction per cycle; each stage, normalization cell and CORDIC cell
// is one register stage, and the whole chain stalls only when the output buffer is full.
// Reset: synchronous, active low on aresetn; clears all stage valid bits and the output buffer.
// Depends on vab_pkg, vab_norm_cell, vab_cordic_cell and vab_skid.
`default_nettype none

module vector_angle_between #(
    parameter int CORDIC_STEPS = vab_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire vab_pkg::vab_in_t  s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output vab_pkg::vab_out_t     m_data
);

    localparam int PW = vab_pkg::PROD_W;
    localparam int SW = vab_pkg::SUM_W;
    localparam int NW = vab_pkg::NEG_W;
    localparam int NS = vab_pkg::NORM_STAGES;

    logic adv;
    logic skid_ready;

    // Stage 1: products.
    logic                 p_valid_reg;
    logic                 p_degen_reg;
    logic                 p_degen_next;
    logic signed [PW-1:0] p_axbx_reg;
    logic signed [PW-1:0] p_ayby_reg;
    logic signed [PW-1:0] p_axby_reg;
    logic signed [PW-1:0] p_aybx_reg;

    // Stage 2: cross and dot.
    logic                 s2_valid_reg;
    logic                 s2_degen_reg;
    logic signed [SW-1:0] cross_reg;
    logic signed [SW-1:0] dot_reg;

    // Stage 3: half-plane fold.
    logic                 s3_valid_reg;
    logic                 s3_degen_reg;
    logic signed [NW-1:0] fx_reg;
    logic signed [NW-1:0] fy_reg;
    logic signed [NW-1:0] fx_next;
    logic signed [NW-1:0] fy_next;
    logic [vab_pkg::Z_W-1:0] fz_reg;
    logic [vab_pkg::Z_W-1:0] fz_next;

    // Stage 4: magnitude for normalization.
    logic signed [NW-1:0] abs_y;
    vab_pkg::vab_norm_t   norm_chain [0:NS];
    vab_pkg::vab_norm_t   norm_next;
    vab_pkg::vab_norm_t   norm_head_reg;
    vab_pkg::vab_rot_t    rot_chain [0:CORDIC_STEPS];

    // Rounding stage.
    logic                         out_valid_reg;
    vab_pkg::vab_out_t            out_reg;
    vab_pkg::vab_out_t            out_next;
    logic [vab_pkg::Z_W-1:0]      round_sum;

    assign adv     = !out_valid_reg || skid_ready;
    assign s_ready = adv;

    always_comb begin
        p_degen_next = ((s_data.first_x == '0) && (s_data.first_y == '0)) ||
                       ((s_data.second_x == '0) && (s_data.second_y == '0));
        if (dot_reg[SW-1]) begin
            fx_next = -NW'(dot_reg);
            fy_next = -NW'(cross_reg);
            fz_next = vab_pkg::HALF_TURN;
        end else begin
            fx_next = NW'(dot_reg);
            fy_next = NW'(cross_reg);
            fz_next = '0;
        end
        abs_y                = fy_reg[NW-1] ? -fy_reg : fy_reg;
        norm_next.valid      = s3_valid_reg;
        norm_next.degenerate = s3_degen_reg;
        norm_next.x          = vab_pkg::XY_W'(fx_reg);
        norm_next.y          = vab_pkg::XY_W'(fy_reg);
        norm_next.z          = fz_reg;
        norm_next.mag        = (abs_y > fx_reg) ? vab_pkg::M_W'(unsigned'(abs_y))
                                                : vab_pkg::M_W'(unsigned'(fx_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg         <= 1'b0;
            s2_valid_reg        <= 1'b0;
            s3_valid_reg        <= 1'b0;
            norm_head_reg.valid <= 1'b0;
        end else if (adv) begin
            p_valid_reg         <= s_valid;
            s2_valid_reg        <= p_valid_reg;
            s3_valid_reg        <= s2_valid_reg;
            norm_head_reg.valid <= norm_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_degen_reg              <= p_degen_next;
            p_axbx_reg               <= PW'(s_data.first_x * s_data.second_x);
            p_ayby_reg               <= PW'(s_data.first_y * s_data.second_y);
            p_axby_reg               <= PW'(s_data.first_x * s_data.second_y);
            p_aybx_reg               <= PW'(s_data.first_y * s_data.second_x);
            s2_degen_reg             <= p_degen_reg;
            cross_reg                <= SW'(p_axby_reg) - SW'(p_aybx_reg);
            dot_reg                  <= SW'(p_axbx_reg) + SW'(p_ayby_reg);
            s3_degen_reg             <= s2_degen_reg;
            fx_reg                   <= fx_next;
            fy_reg                   <= fy_next;
            fz_reg                   <= fz_next;
            norm_head_reg.degenerate <= norm_next.degenerate;
            norm_head_reg.x          <= norm_next.x;
            norm_head_reg.y          <= norm_next.y;
            norm_head_reg.z          <= norm_next.z;
            norm_head_reg.mag        <= norm_next.mag;
        end
    end

    assign norm_chain[0] = norm_head_reg;

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_norm
            vab_norm_cell #(
                .SHIFT(1 << (NS - 1 - g))
            ) u_norm (
                .aclk    (aclk),
                .aresetn (aresetn),
                .adv     (adv),
                .cell_in (norm_chain[g]),
                .cell_out(norm_chain[g+1])
            );
        end
    endgenerate

    assign rot_chain[0].valid      = norm_chain[NS].valid;
    assign rot_chain[0].degenerate = norm_chain[NS].degenerate;
    assign rot_chain[0].x          = norm_chain[NS].x;
    assign rot_chain[0].y          = norm_chain[NS].y;
    assign rot_chain[0].z          = norm_chain[NS].z;

    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
            vab_cordic_cell #(
                .STEP(g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .adv     (adv),
                .cell_in (rot_chain[g]),
                .cell_out(rot_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        round_sum           = rot_chain[CORDIC_STEPS].z + vab_pkg::ROUND_HALF;
        out_next.degenerate = rot_chain[CORDIC_STEPS].degenerate;
        if (rot_chain[CORDIC_STEPS].degenerate) begin
            out_next.turn_angle = '0;
        end else begin
            out_next.turn_angle = round_sum[vab_pkg::Z_W-1 -: vab_pkg::ANGLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= rot_chain[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    vab_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (out_valid_reg),
        .in_ready (skid_ready),
        .in_data  (out_reg),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.turn_angle == '0)
        else $error("Degenerate result carries a nonzero angle.");

    a_normalized : assert property (@(posedge aclk) disable iff (!aresetn)
        norm_chain[NS].valid && !norm_chain[NS].degenerate |->
            norm_chain[NS].mag[vab_pkg::M_W-1] && !norm_chain[NS].x[vab_pkg::XY_W-1])
        else $error("Vector entering the CORDIC chain is not normalized to the right half.");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !skid_ready |=> out_valid_reg && $stable(out_reg))
        else $error("Rounded result changed while the output buffer was full.");

endmodule

`default_nettype wire

FILE: sim/angle_checker.sv
// Checker for the vector angle block: watches both channels, predicts each result
// with a bit-accurate CORDIC model and compares it with what the block delivers.
// Depends on vab_pkg for the payload types and fixed-point widths.
module angle_checker #(
    parameter int STEPS = vab_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  vab_pkg::vab_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  vab_pkg::vab_out_t m_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import vab_pkg::*;

    typedef struct packed {
        vab_in_t  req;
        vab_out_t res;
    } angle_job_t;

    logic [63:0] atan_tab [STEPS];
    angle_job_t  expected_angles [$];

    // Arctangent of 2^-step as a fraction of a turn, Q62.
    function automatic logic [63:0] atan_step(input int step);
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] prod;
        int           k;
        if (step == 0) begin
            return 64'd1 << (FRAC_BITS - 3);
        end
        rad = 64'd0;
        k   = 0;
        while (step * (2 * k + 1) <= FRAC_BITS) begin
            term = (64'd1 << (FRAC_BITS - step * (2 * k + 1))) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                rad = rad - term;
            end else begin
                rad = rad + term;
            end
            k++;
        end
        prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
        return prod[127:64];
    endfunction

    function automatic logic signed [63:0] widen(input logic [COORD_BITS-1:0] c);
        return {{(64 - COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    function automatic vab_out_t predict_angle(input vab_in_t v);
        logic signed [63:0] ax, ay, bx, by;
        logic signed [63:0] x, y, xs, ys;
        logic [63:0]        z, mag, ymag, r;
        vab_out_t           res;
        int                 i;
        res = '0;
        ax  = widen(v.first_x);
        ay  = widen(v.first_y);
        bx  = widen(v.second_x);
        by  = widen(v.second_y);
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
            res.degenerate = 1'b1;
            return res;
        end
        y = ax * by - ay * bx;
        x = ax * bx + ay * by;
        z = 64'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'd1 << (FRAC_BITS - 1);
        end
        mag  = (x < 0) ? 64'(-x) : 64'(x);
        ymag = (y < 0) ? 64'(-y) : 64'(y);
        if (ymag > mag) begin
            mag = ymag;
        end
        while (mag < (64'd1 << 59)) begin
            x   = x <<< 1;
            y   = y <<< 1;
            mag = mag << 1;
        end
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
        end
        z = z & ((64'd1 << FRAC_BITS) - 64'd1);
        r = (z + (64'd1 << (FRAC_BITS - ANGLE_BITS - 1))) >> (FRAC_BITS - ANGLE_BITS);
        res.turn_angle = r[ANGLE_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i < STEPS; i++) begin
            atan_tab[i] = atan_step(i);
        end
    end

    always @(posedge aclk) begin : watch
        angle_job_t job;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    job = expected_angles.pop_front();
                    if (m_data.turn_angle !== job.res.turn_angle) begin
                        report_mismatch($sformatf(
                            "a=(%0d,%0d) b=(%0d,%0d) turn_angle %h, expected %h",
                            job.req.first_x, job.req.first_y, job.req.second_x,
                            job.req.second_y, m_data.turn_angle, job.res.turn_angle));
                    end
                    if (m_data.degenerate !== job.res.degenerate) begin
                        report_mismatch($sformatf(
                            "a=(%0d,%0d) b=(%0d,%0d) degenerate %b, expected %b",
                            job.req.first_x, job.req.first_y, job.req.second_x,
                            job.req.second_y, m_data.degenerate, job.res.degenerate));
                    end
                end
            end
            if (s_valid && s_ready) begin
                job.req = s_data;
                job.res = predict_angle(s_data);
                expected_angles.push_back(job);
            end
            pending <= expected_angles.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the vector angle testbench: clock, reset, directed and random vector pairs,
// random idling on both channels and the final verdict.
// Depends on vab_pkg, vector_angle_between and angle_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vab_pkg::*;

    localparam int FLUSH_CYCLES = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    vab_in_t  s_data  = '0;
    logic     m_ready = 1'b0;
    logic     s_ready;
    logic     m_valid;
    vab_out_t m_data;
    int       send_idle = 15;
    int       recv_idle = 86;
    int       mismatches;
    int       pending;

    always #6 aclk = ~aclk;

    vector_angle_between dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    angle_checker angle_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (mismatches),
        .pending    (pending)
    );

    function automatic vab_in_t pair(input int ax, input int ay, input int bx, input int by);
        vab_in_t v;
        v.first_x  = COORD_BITS'(ax);
        v.first_y  = COORD_BITS'(ay);
        v.second_x = COORD_BITS'(bx);
        v.second_y = COORD_BITS'(by);
        return v;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return COORD_BITS'(-32768);
                    1: return COORD_BITS'(-1);
                    2: return '0;
                    3: return COORD_BITS'(1);
                    default: return COORD_BITS'(32767);
                endcase
            end
            1, 2: return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic vab_in_t rand_pair();
        vab_in_t v;
        int      ax;
        int      ay;
        int      k;
        v  = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        ax = int'($urandom_range(0, 200)) - 100;
        ay = int'($urandom_range(0, 200)) - 100;
        k  = int'($urandom_range(0, 200)) - 100;
        case ($urandom_range(0, 19))
            0: begin
                if ($urandom_range(0, 1) == 0) begin
                    v.first_x = '0;
                    v.first_y = '0;
                end else begin
                    v.second_x = '0;
                    v.second_y = '0;
                end
            end
            1: v = pair(ax, ay, k * ax, k * ay);
            2: v = pair(ax, ay, -k * ay, k * ax);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(input vab_in_t item);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            send_item(rand_pair());
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Axis directions, wrap just below a full turn, extremes and zero vectors.
        send_item(pair(1, 0, 0, 1));
        send_item(pair(1, 0, -1, 0));
        send_item(pair(1, 0, 0, -1));
        send_item(pair(1, 0, 1, 0));
        send_item(pair(0, 1, 1, 0));
        send_item(pair(32767, 32767, -32768, -32768));
        send_item(pair(-32768, -32768, -32768, -32768));
        send_item(pair(32767, -32768, -32768, 32767));
        send_item(pair(-32768, 0, 0, -32768));
        send_item(pair(32767, 0, 0, 32767));
        send_item(pair(0, 0, 5, 7));
        send_item(pair(3, -4, 0, 0));
        send_item(pair(0, 0, 0, 0));
        send_item(pair(-32768, -32768, 32767, -32768));
        send_item(pair(1, 1, -1, 1));
        send_item(pair(1, 1, 1, -1));
        send_item(pair(-1, -1, 1, 1));
        send_item(pair(3, 4, 4, 3));
        send_item(pair(4, 3, 3, 4));
        send_item(pair(32767, 1, 32767, -1));
        send_item(pair(-1, 0, 1, 0));
        send_item(pair(0, -32768, 32767, 0));
        send_item(pair(-32768, 32767, 32767, -32768));
        send_item(pair(1, 0, -32768, -1));

        run_random(220);
        send_idle = 86;
        recv_idle = 15;
        run_random(220);
        send_idle = 0;
        recv_idle = 0;
        run_random(210);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (FLUSH_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
